// ===== src/ir2d_pkg.sv =====
`default_nettype none

package ir2d_pkg;

  // ascii anchors for digit characters
  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_ALPHA = 7'd65;
  localparam logic [3:0] DEC_LIMIT  = 4'd9;

  // base register limits and reset
  localparam logic [4:0] RADIX_MIN   = 5'd2;
  localparam logic [4:0] RADIX_MAX   = 5'd16;
  localparam logic [4:0] RADIX_RESET = 5'd2;

  // quotient bits resolved by the divider per cycle
  localparam int STEP_BITS = 8;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_READ = 4'b0100,
    ST_SHOW = 4'b1000
  } state_t;

  // divider status towards the sequencer
  typedef struct packed {
    logic       done;
    logic [3:0] rem;
  } div_stat_t;

  // clamp the base register into 2..16
  function automatic logic [4:0] sat_radix(input logic [4:0] r);
    logic [4:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  // digit value to ascii character
  function automatic logic [6:0] to_ascii(input logic [3:0] d);
    logic [6:0] res;
    if (d <= DEC_LIMIT) res = CHAR_ZERO + {3'd0, d};
    else res = CHAR_ALPHA + {3'd0, d} - 7'd10;
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== src/ir2d_if.sv =====
`default_nettype none

// input beat: one value to convert
interface ir2d_in_if #(parameter int VALUE_WIDTH = 30);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// output beat: one digit character
interface ir2d_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] digit_char;
  logic       last_digit;
  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// configuration write: the base register
interface ir2d_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] radix;
  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

`default_nettype wire

// ===== src/ir2d_divider.sv =====
`default_nettype none

module ir2d_divider #(
  parameter int VALUE_WIDTH = 30
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] dividend,
  input  wire logic [4:0]             base,
  output      logic [VALUE_WIDTH-1:0] quotient,
  output      ir2d_pkg::div_stat_t    stat
);

  localparam int STEP   = ir2d_pkg::STEP_BITS;
  localparam int CHUNKS = (VALUE_WIDTH + STEP - 1) / STEP;
  localparam int PAD_W  = CHUNKS * STEP;
  localparam int CNT_W  = $clog2(CHUNKS + 1);

  logic [PAD_W-1:0] acc;
  logic [PAD_W-1:0] acc_next;
  logic [3:0]       rem;
  logic [3:0]       rem_next;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic             done;

  // restoring long division, several quotient bits a cycle
  always_comb begin
    logic [4:0] t;
    acc_next = acc;
    rem_next = rem;
    for (int i = 0; i < STEP; i++) begin
      t = {rem_next, acc_next[PAD_W-1]};
      acc_next = {acc_next[PAD_W-2:0], 1'b0};
      if (t >= base) begin
        t = t - base;
        acc_next[0] = 1'b1;
      end
      rem_next = t[3:0];
    end
  end

  // chunk counter and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      cnt     <= CNT_W'(CHUNKS);
    end else if (running) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= PAD_W'(dividend);
      rem <= '0;
    end else if (running) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  assign quotient  = acc[VALUE_WIDTH-1:0];
  assign stat.done = done;
  assign stat.rem  = rem;

endmodule

`default_nettype wire

// ===== src/ir2d_digit_store.sv =====
`default_nettype none

module ir2d_digit_store #(
  parameter int DEPTH = 30,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [3:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output      logic [3:0]    rdata
);

  logic [3:0] mem [DEPTH];

  // remainder write, least significant first
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/integer_to_radix_digits_unit.sv =====
`default_nettype none

// Converts an unsigned VALUE_WIDTH-bit integer into its digits in the base held
// in the radix register (2 to 16; smaller values act as 2, larger as 16) and
// sends them most significant first as ascii characters '0'-'9', 'A'-'F', one
// beat per digit, last_digit set on the final one. Zero gives the single digit
// '0'. Digits come from repeated division by one shared divider that resolves
// eight quotient bits a cycle. Each remainder goes into a small digit memory,
// from which the digits are then read back, and no new value is taken until
// its last digit has been delivered. The radix register may be written only
// while the unit is idle.
module integer_to_radix_digits_unit #(
  parameter int VALUE_WIDTH = 30
) (
  input wire logic       clk,
  input wire logic       rst,
  ir2d_cfg_if.sink       cfg,
  ir2d_in_if.sink        din,
  ir2d_out_if.source     dout
);

  localparam int CW = $clog2(VALUE_WIDTH + 1);
  localparam int AW = $clog2(VALUE_WIDTH);

  ir2d_pkg::state_t    state;
  logic [4:0]          radix;
  logic [CW-1:0]       digit_count;
  logic [CW-1:0]       count_inc;
  logic [AW-1:0]       rd_idx;
  logic                in_fire;
  logic                out_fire;
  logic                div_start;
  logic                step_done;
  logic [VALUE_WIDTH-1:0] div_quo;
  logic [VALUE_WIDTH-1:0] dividend;
  ir2d_pkg::div_stat_t div_stat;
  logic [3:0]          rd_data;

  // base register
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) radix <= ir2d_pkg::RADIX_RESET;
    else if (cfg.valid) radix <= cfg.radix;
  end

  // handshakes
  assign din.ready = (state == ir2d_pkg::ST_IDLE);
  assign in_fire   = din.valid && din.ready;
  assign out_fire  = dout.valid && dout.ready;
  assign step_done = (state == ir2d_pkg::ST_DIV) && div_stat.done;

  // divider launch on a new value or on a non-zero quotient
  assign div_start = in_fire || (step_done && div_quo != '0);
  assign dividend  = (state == ir2d_pkg::ST_IDLE) ? din.value : div_quo;

  ir2d_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .base     (ir2d_pkg::sat_radix(radix)),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // digit count saturates at the store depth
  assign count_inc = (digit_count < CW'(VALUE_WIDTH)) ? digit_count + 1'b1 : digit_count;

  ir2d_digit_store #(
    .DEPTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (step_done && digit_count < CW'(VALUE_WIDTH)),
    .waddr (digit_count[AW-1:0]),
    .wdata (div_stat.rem),
    .re    (state == ir2d_pkg::ST_READ),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ir2d_pkg::ST_IDLE;
      digit_count <= '0;
      rd_idx      <= '0;
    end else begin
      case (state)
        ir2d_pkg::ST_IDLE: begin
          if (in_fire) begin
            state       <= ir2d_pkg::ST_DIV;
            digit_count <= '0;
          end
        end
        ir2d_pkg::ST_DIV: begin
          if (div_stat.done) begin
            digit_count <= count_inc;
            if (div_quo == '0) begin
              state  <= ir2d_pkg::ST_READ;
              rd_idx <= AW'(count_inc - 1'b1);
            end
          end
        end
        ir2d_pkg::ST_READ: begin
          state <= ir2d_pkg::ST_SHOW;
        end
        ir2d_pkg::ST_SHOW: begin
          if (out_fire) begin
            if (rd_idx == '0) begin
              state <= ir2d_pkg::ST_IDLE;
            end else begin
              state  <= ir2d_pkg::ST_READ;
              rd_idx <= rd_idx - 1'b1;
            end
          end
        end
        default: begin
          state <= ir2d_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // output beat straight from the registered store read
  assign dout.valid      = (state == ir2d_pkg::ST_SHOW);
  assign dout.digit_char = ir2d_pkg::to_ascii(rd_data);
  assign dout.last_digit = (rd_idx == '0);

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= CW'(VALUE_WIDTH))
    else $error("digit count beyond store depth");

  a_accept_to_div: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == ir2d_pkg::ST_DIV)
    else $error("accepted value did not start division");

  a_zero_quo_read: assert property (@(posedge clk) disable iff (rst)
    (step_done && div_quo == '0) |=> state == ir2d_pkg::ST_READ)
    else $error("final quotient did not start read-out");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_fire && dout.last_digit) |=> state == ir2d_pkg::ST_IDLE)
    else $error("unit not idle after last digit");

  a_no_done_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ir2d_pkg::ST_SHOW || state == ir2d_pkg::ST_READ) |-> !div_stat.done)
    else $error("divider finished during read-out");

endmodule

`default_nettype wire
